/* rtl/h2r_pkg.sv */
// Shared types, constants and helper functions for the HSI-to-RGBW converter.
// No dependencies; used by h2r_div_lane and hsi8_to_rgbw_convert_unit.
`default_nettype none

package h2r_pkg;

    localparam int PIX_W      = 8;                 // width of every port field
    localparam int CH_W       = 10;                // channel value before scaling
    localparam int NUM_W      = CH_W + PIX_W;      // channel * 255
    localparam int STAGES     = 7;                 // total register stages
    localparam int DIV_STAGES = 4;                 // stages inside the divider
    localparam int DIV_STEPS  = PIX_W / DIV_STAGES; // quotient bits per stage

    localparam logic [PIX_W-1:0] MIN_LEVEL = 8'd10;
    localparam logic [PIX_W-1:0] FULL      = 8'd255;

    // hue sector boundaries for the channel ordering
    localparam logic [PIX_W-1:0] SEC_B1 = 8'd43;
    localparam logic [PIX_W-1:0] SEC_B2 = 8'd85;
    localparam logic [PIX_W-1:0] SEC_B3 = 8'd128;
    localparam logic [PIX_W-1:0] SEC_B4 = 8'd170;
    localparam logic [PIX_W-1:0] SEC_B5 = 8'd213;

    typedef enum logic [2:0] {
        SEC_RED_GREEN,    // r=C g=X b=0
        SEC_GREEN_RED,    // r=X g=C b=0
        SEC_GREEN_BLUE,   // r=0 g=C b=X
        SEC_BLUE_GREEN,   // r=0 g=X b=C
        SEC_BLUE_RED,     // r=X g=0 b=C
        SEC_RED_BLUE      // r=C g=0 b=X
    } sector_t;

    // partial remainder plus the dividend/quotient shift word
    typedef struct packed {
        logic [CH_W-1:0]  rem;
        logic [PIX_W-1:0] lq;
    } div_state_t;

    function automatic sector_t hue_sector(logic [PIX_W-1:0] h);
        sector_t s;
        if (h < SEC_B1)      s = SEC_RED_GREEN;
        else if (h < SEC_B2) s = SEC_GREEN_RED;
        else if (h < SEC_B3) s = SEC_GREEN_BLUE;
        else if (h < SEC_B4) s = SEC_BLUE_GREEN;
        else if (h < SEC_B5) s = SEC_BLUE_RED;
        else                 s = SEC_RED_BLUE;
        return s;
    endfunction

    // Triangle-wave hue table, 256 entries
    function automatic logic [PIX_W-1:0] hue_rom(logic [PIX_W-1:0] h);
        logic [PIX_W:0] v;
        if (h < 8'd43)       v = 9'(9'd6 * h);
        else if (h < 8'd86)  v = 9'(9'd255 - 9'd6 * 9'(h - 8'd43));
        else if (h < 8'd128) v = 9'(9'd3 + 9'd6 * 9'(h - 8'd86));
        else if (h < 8'd171) v = 9'(9'd255 - 9'd6 * 9'(h - 8'd128));
        else if (h < 8'd214) v = 9'(9'd3 + 9'd6 * 9'(h - 8'd171));
        else                 v = 9'(9'd252 - 9'd6 * 9'(h - 8'd214));
        return v[PIX_W-1:0];
    endfunction

    // One restoring-division step: shift in the next dividend bit, subtract if it fits.
    function automatic div_state_t div_step(div_state_t st, logic [CH_W-1:0] den);
        logic [CH_W:0] t;
        logic          qb;
        div_state_t    o;
        t  = {st.rem, st.lq[PIX_W-1]};
        qb = (t >= {1'b0, den});
        if (qb)
            o.rem = CH_W'(t - {1'b0, den});
        else
            o.rem = t[CH_W-1:0];
        o.lq = {st.lq[PIX_W-2:0], qb};
        return o;
    endfunction

endpackage

`default_nettype wire

/* rtl/h2r_div_lane.sv */
// Pipelined restoring divider for one color channel: quo = num / den, quo < 256.
// Depends on h2r_pkg; stage loads come from the pipeline control in the top level.
`default_nettype none

module h2r_div_lane (
    input  wire logic                          clk,
    input  wire logic [h2r_pkg::DIV_STAGES-1:0] load,
    input  wire logic [h2r_pkg::NUM_W-1:0]      num,
    input  wire logic [h2r_pkg::CH_W-1:0]       den,
    output logic      [h2r_pkg::PIX_W-1:0]      quo
);

    h2r_pkg::div_state_t             st_reg   [h2r_pkg::DIV_STAGES];
    h2r_pkg::div_state_t             st_next  [h2r_pkg::DIV_STAGES];
    logic [h2r_pkg::CH_W-1:0]        den_reg  [h2r_pkg::DIV_STAGES-1];

    always_comb
    begin
        h2r_pkg::div_state_t cur;
        logic [h2r_pkg::CH_W-1:0] d;
        for (int j = 0; j < h2r_pkg::DIV_STAGES; j++)
        begin
            if (j == 0)
            begin
                cur.rem = num[h2r_pkg::NUM_W-1:h2r_pkg::PIX_W];
                cur.lq  = num[h2r_pkg::PIX_W-1:0];
                d       = den;
            end
            else
            begin
                cur = st_reg[j-1];
                d   = den_reg[j-1];
            end
            for (int k = 0; k < h2r_pkg::DIV_STEPS; k++)
                cur = h2r_pkg::div_step(cur, d);
            st_next[j] = cur;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < h2r_pkg::DIV_STAGES; j++)
        begin
            if (load[j])
                st_reg[j] <= st_next[j];
        end
        if (load[0])
            den_reg[0] <= den;
        for (int j = 1; j < h2r_pkg::DIV_STAGES - 1; j++)
        begin
            if (load[j])
                den_reg[j] <= den_reg[j-1];
        end
    end

    assign quo = st_reg[h2r_pkg::DIV_STAGES-1].lq;

endmodule

`default_nettype wire

/* rtl/hsi8_to_rgbw_convert_unit.sv */
// HSI plus alpha to RGBW plus alpha converter, seven register stages.
// Throughput is one beat per cycle while out_ready does not stall the output.
// Out-of-gamut scaling runs through a 4-stage restoring divider, 2 quotient bits a stage.
// Each stage holds its beat while the next stage is full and stalled; bubbles collapse.
// Reset (rst_n, async, active low) clears all stage valid bits; data registers are not reset.
// Depends on h2r_pkg and h2r_div_lane.
`default_nettype none

module hsi8_to_rgbw_convert_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] hue,
    input  wire logic [7:0] saturation,
    input  wire logic [7:0] intensity,
    input  wire logic [7:0] alpha,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      red,
    output logic [7:0]      green,
    output logic [7:0]      blue,
    output logic [7:0]      white,
    output logic [7:0]      alpha_out
);

    localparam int N  = h2r_pkg::STAGES;
    localparam int DS = h2r_pkg::DIV_STAGES;
    localparam int DB = N - DS;   // first divider stage

    // ---------------- pipeline control ----------------
    logic [N-1:0] valid_reg, valid_next;
    logic [N-1:0] load, free;

    always_comb
    begin
        for (int k = N - 1; k >= 0; k--)
        begin
            if (k == N - 1)
                free[k] = !valid_reg[k] || out_ready;
            else
                free[k] = !valid_reg[k] || load[k+1];
            if (k == 0)
                load[k] = in_valid && free[k];
            else
                load[k] = valid_reg[k-1] && free[k];
            valid_next[k] = load[k] || (valid_reg[k] && !free[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign in_ready  = free[0];
    assign out_valid = valid_reg[N-1];

    // ---------------- stage 1: products, table lookup, sector ----------------
    logic [7:0]       w1_reg, a1_reg, z1_reg;
    logic [15:0]      is1_reg;
    h2r_pkg::sector_t sec1_reg;
    logic             dim1_reg;

    logic        dim;
    logic [15:0] wprod;

    assign dim   = (intensity < h2r_pkg::MIN_LEVEL) || (alpha < h2r_pkg::MIN_LEVEL);
    assign wprod = intensity * (h2r_pkg::FULL - saturation);

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            w1_reg   <= dim ? 8'd0 : wprod[15:8];
            a1_reg   <= dim ? 8'd0 : alpha;
            is1_reg  <= intensity * saturation;
            z1_reg   <= h2r_pkg::hue_rom(hue);
            sec1_reg <= h2r_pkg::hue_sector(hue);
            dim1_reg <= dim;
        end
    end

    // ---------------- stage 2: chroma C and X ----------------
    logic [9:0]       c2_reg, x2_reg;
    logic [7:0]       w2_reg, a2_reg;
    h2r_pkg::sector_t sec2_reg;
    logic             dim2_reg;

    logic [17:0] c3prod;
    logic [9:0]  c_val;
    logic [17:0] xprod;

    assign c3prod = {2'b00, is1_reg} + {1'b0, is1_reg, 1'b0};
    assign c_val  = c3prod[17:8];
    assign xprod  = c_val * z1_reg;

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            c2_reg   <= c_val;
            x2_reg   <= xprod[17:8];
            w2_reg   <= w1_reg;
            a2_reg   <= a1_reg;
            sec2_reg <= sec1_reg;
            dim2_reg <= dim1_reg;
        end
    end

    // ---------------- stage 3: sector ordering plus offset ----------------
    logic [9:0] r3_reg, g3_reg, b3_reg;
    logic [7:0] w3_reg, a3_reg;
    logic       dim3_reg;

    logic [9:0] r_pre, g_pre, b_pre;

    always_comb
    begin
        r_pre = '0;
        g_pre = '0;
        b_pre = '0;
        case (sec2_reg)
            h2r_pkg::SEC_RED_GREEN:
            begin
                r_pre = c2_reg;
                g_pre = x2_reg;
            end
            h2r_pkg::SEC_GREEN_RED:
            begin
                r_pre = x2_reg;
                g_pre = c2_reg;
            end
            h2r_pkg::SEC_GREEN_BLUE:
            begin
                g_pre = c2_reg;
                b_pre = x2_reg;
            end
            h2r_pkg::SEC_BLUE_GREEN:
            begin
                g_pre = x2_reg;
                b_pre = c2_reg;
            end
            h2r_pkg::SEC_BLUE_RED:
            begin
                r_pre = x2_reg;
                b_pre = c2_reg;
            end
            h2r_pkg::SEC_RED_BLUE:
            begin
                r_pre = c2_reg;
                b_pre = x2_reg;
            end
            default:
            begin
                r_pre = '0;
                g_pre = '0;
                b_pre = '0;
            end
        endcase
    end

    // C + w never exceeds 762, so ten bits hold every channel
    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            r3_reg   <= 10'(r_pre + {2'b00, w2_reg});
            g3_reg   <= 10'(g_pre + {2'b00, w2_reg});
            b3_reg   <= 10'(b_pre + {2'b00, w2_reg});
            w3_reg   <= w2_reg;
            a3_reg   <= a2_reg;
            dim3_reg <= dim2_reg;
        end
    end

    // ---------------- divider setup: num = ch * 255, den = max or 255 ----------------
    logic [9:0]  mx_rg, mx, den;
    logic [17:0] num_r, num_g, num_b;

    assign mx_rg = (g3_reg > r3_reg) ? g3_reg : r3_reg;
    assign mx    = (b3_reg > mx_rg) ? b3_reg : mx_rg;
    // in gamut: dividing by 255 returns the channel unchanged
    assign den   = (mx > 10'd255) ? mx : 10'd255;

    // dim beats drive zero into the divider
    assign num_r = dim3_reg ? 18'd0 : ({r3_reg, 8'd0} - {8'd0, r3_reg});
    assign num_g = dim3_reg ? 18'd0 : ({g3_reg, 8'd0} - {8'd0, g3_reg});
    assign num_b = dim3_reg ? 18'd0 : ({b3_reg, 8'd0} - {8'd0, b3_reg});

    h2r_div_lane u_div_red (
        .clk  (clk),
        .load (load[N-1:DB]),
        .num  (num_r),
        .den  (den),
        .quo  (red)
    );

    h2r_div_lane u_div_green (
        .clk  (clk),
        .load (load[N-1:DB]),
        .num  (num_g),
        .den  (den),
        .quo  (green)
    );

    h2r_div_lane u_div_blue (
        .clk  (clk),
        .load (load[N-1:DB]),
        .num  (num_b),
        .den  (den),
        .quo  (blue)
    );

    // carry white and alpha alongside the divider
    logic [7:0] w_div_reg [DS];
    logic [7:0] a_div_reg [DS];

    always_ff @(posedge clk)
    begin
        if (load[DB])
        begin
            w_div_reg[0] <= w3_reg;
            a_div_reg[0] <= a3_reg;
        end
        for (int j = 1; j < DS; j++)
        begin
            if (load[DB+j])
            begin
                w_div_reg[j] <= w_div_reg[j-1];
                a_div_reg[j] <= a_div_reg[j-1];
            end
        end
    end

    assign white     = w_div_reg[DS-1];
    assign alpha_out = a_div_reg[DS-1];

endmodule

`default_nettype wire
